>>> rtl/vibt_pkg.sv
// shared types and constants for the video bus interface and scan timing block
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package vibt_pkg;

  // field widths fixed by the bus format
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned PORT_W  = 3;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LINE_W  = 9;
  localparam int unsigned PA_W    = 11;
  localparam int unsigned MODE_W  = 5;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFGIX_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PORT_WR = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PAGE_RD = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PAGE_WR = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CHAR_RD = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CHAR_WR = 3'd5;

  // output port numbers that change state seen by the bus side
  localparam logic [PORT_W-1:0] PORT_MODE = 3'd5;
  localparam logic [PORT_W-1:0] PORT_PTR  = 3'd6;

  // mode bit positions
  localparam int unsigned MB_CMEM     = 0;
  localparam int unsigned MB_LINE9    = 1;
  localparam int unsigned MB_LINE16   = 2;
  localparam int unsigned MB_DBLPAGE  = 3;
  localparam int unsigned MB_FRESVERT = 4;

  // configuration register indexes
  localparam logic [CFGIX_W-1:0] CFG_PAGE_MASK  = 2'd0;
  localparam logic [CFGIX_W-1:0] CFG_FIRST_LINE = 2'd1;
  localparam logic [CFGIX_W-1:0] CFG_END_LINE   = 2'd2;
  localparam logic [CFGIX_W-1:0] CFG_IRQ_LINE   = 2'd3;

  // configuration reset values
  localparam logic [PA_W-1:0]   RST_PAGE_MASK  = 11'd2047;
  localparam logic [LINE_W-1:0] RST_FIRST_LINE = 9'd36;
  localparam logic [LINE_W-1:0] RST_END_LINE   = 9'd228;
  localparam logic [LINE_W-1:0] RST_IRQ_LINE   = 9'd32;

  localparam logic [DATA_W-1:0] IDLE_BYTE = 8'hff;

  // controller to datapath commands
  typedef struct packed {
    logic clear;       // one step of the memory clearing sweep
    logic take_in;     // latch the accepted item
    logic exec_page;   // page ram access, tick and port updates
    logic exec_glyph;  // glyph ram access
    logic load_out;    // load the result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;  // last entry of the clearing sweep
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/vibt_if.sv
// request and result channel interfaces for the video bus block
// depends on vibt_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface vibt_req_if import vibt_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [PORT_W-1:0] port;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] data;
  logic              q_line;

  modport source (output valid, req_type, port, address, data, q_line, input ready);
  modport sink (input valid, req_type, port, address, data, q_line, output ready);
endinterface

interface vibt_rsp_if import vibt_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              color_bit;
  logic              irq;
  logic              in_blanking;

  modport source (output valid, read_data, color_bit, irq, in_blanking, input ready);
  modport sink (input valid, read_data, color_bit, irq, in_blanking, output ready);
endinterface

`default_nettype wire

>>> rtl/vibt_ctrl.sv
// sequencing state machine for the video bus block
// depends on vibt_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module vibt_ctrl import vibt_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PAGE  = 3'd2;
  localparam logic [2:0] S_GLYPH = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_FIN) && out_free);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.take_in      = accept;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_PAGE;
        end
      end
      S_PAGE: begin
        cmd_o.exec_page = 1'b1;
        state_d         = S_GLYPH;
      end
      S_GLYPH: begin
        cmd_o.exec_glyph = 1'b1;
        state_d          = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = accept ? S_PAGE : S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/vibt_dp.sv
// datapath of the video bus block: page and glyph rams, scan counters,
// mode registers, configuration and the result register; uses vibt_pkg
`timescale 1ns / 1ps
`default_nettype none

module vibt_dp import vibt_pkg::*; #(
  parameter int unsigned PAGE_DEPTH      = 2048,
  parameter int unsigned GLYPH_DEPTH     = 4096,
  parameter int unsigned CYCLES_PER_LINE = 14,
  parameter int unsigned LINES_PER_FRAME = 262
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  wire                cfg_we_i,
  input  wire [CFGIX_W-1:0]  cfg_idx_i,
  input  wire [CFG_W-1:0]    cfg_data_i,
  input  wire [REQ_W-1:0]    req_type_i,
  input  wire [PORT_W-1:0]   port_i,
  input  wire [ADDR_W-1:0]   address_i,
  input  wire [DATA_W-1:0]   data_i,
  input  wire                q_line_i,
  output logic [DATA_W-1:0]  read_data_o,
  output logic               color_bit_o,
  output logic               irq_o,
  output logic               in_blanking_o
);

  localparam int unsigned PAW = $clog2(PAGE_DEPTH);
  localparam int unsigned GAW = $clog2(GLYPH_DEPTH);
  localparam int unsigned CW  = $clog2(CYCLES_PER_LINE);

  // memories, cleared by the sweep after reset
  logic [DATA_W-1:0] page_mem  [PAGE_DEPTH];
  logic [DATA_W-1:0] glyph_mem [GLYPH_DEPTH];
  logic              color_mem [GLYPH_DEPTH];

  // latched item
  logic [REQ_W-1:0]  req_type_q;
  logic [PORT_W-1:0] port_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] data_q;
  logic              qln_q;

  // control state
  logic [GAW-1:0]    clr_cnt_q;
  logic [MODE_W-1:0] mode_q;
  logic [PA_W-1:0]   ptr_q;
  logic              blank_q;
  logic [LINE_W-1:0] line_q;
  logic [CW-1:0]     cyc_q;
  logic              latched_q;
  logic              irq_q;
  logic [PA_W-1:0]   cfg_mask_q;
  logic [LINE_W-1:0] cfg_first_q;
  logic [LINE_W-1:0] cfg_end_q;
  logic [LINE_W-1:0] cfg_irq_q;

  // ram read data
  logic [DATA_W-1:0] page_rd_q;
  logic [DATA_W-1:0] glyph_rd_q;
  logic              color_rd_q;

  logic [PA_W-1:0]   pa;
  logic [PAW-1:0]    page_idx;
  logic [3:0]        row;
  logic [3:0]        row_mod;
  logic              sel16;
  logic              sel9;
  logic [DATA_W-1:0] column;
  logic [11:0]       col_scaled;
  logic [11:0]       gsum;
  logic [GAW-1:0]    glyph_idx;
  logic              page_clr;
  logic              is_tick;
  logic              blank_new;
  logic              irq_new;
  logic              char_rd_hit;
  logic              color_new;

  // page address: offset, or the pointer in cmem mode
  always_comb begin
    if (mode_q[MB_CMEM]) begin
      pa = mode_q[MB_DBLPAGE] ? ptr_q : {1'b0, ptr_q[9:0]};
    end else begin
      pa = addr_q[PA_W-1:0];
    end
  end

  assign page_idx = PAW'(pa & cfg_mask_q & PA_W'(PAGE_DEPTH - 1));

  // glyph address: column * lines + row mod lines, lines is 8, 9 or 16
  assign sel16 = mode_q[MB_LINE16] && !mode_q[MB_DBLPAGE];
  assign sel9  = !sel16 && !mode_q[MB_LINE9];
  assign row   = mode_q[MB_DBLPAGE] ? {1'b0, addr_q[2:0]} : addr_q[3:0];

  always_comb begin
    if (sel16) begin
      row_mod = row;
    end else if (sel9) begin
      row_mod = (row >= 4'd9) ? row - 4'd9 : row;
    end else begin
      row_mod = {1'b0, row[2:0]};
    end
  end

  assign column = pa[10] ? IDLE_BYTE : page_rd_q;

  always_comb begin
    if (sel16) begin
      col_scaled = {column, 4'b0000};
    end else if (sel9) begin
      col_scaled = {1'b0, column, 3'b000} + {4'b0000, column};
    end else begin
      col_scaled = {1'b0, column, 3'b000};
    end
  end

  assign gsum      = col_scaled + {8'b0, row_mod};
  assign glyph_idx = GAW'(gsum & 12'(GLYPH_DEPTH - 1));

  // clearing sweep covers the glyph depth, page ram takes the lower part
  assign page_clr          = ({1'b0, clr_cnt_q} < (GAW + 1)'(PAGE_DEPTH));
  assign sts_o.clear_last  = (clr_cnt_q == GAW'(GLYPH_DEPTH - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      if (page_clr) begin
        page_mem[clr_cnt_q[PAW-1:0]] <= '0;
      end
    end else if (cmd_i.exec_page) begin
      if ((req_type_q == REQ_PAGE_WR) && blank_q) begin
        page_mem[page_idx] <= data_q;
      end
      page_rd_q <= page_mem[page_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      glyph_mem[clr_cnt_q] <= '0;
      color_mem[clr_cnt_q] <= 1'b0;
    end else if (cmd_i.exec_glyph) begin
      if ((req_type_q == REQ_CHAR_WR) && blank_q) begin
        glyph_mem[glyph_idx] <= data_q;
        color_mem[glyph_idx] <= qln_q;
      end
      glyph_rd_q <= glyph_mem[glyph_idx];
      color_rd_q <= color_mem[glyph_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      req_type_q <= req_type_i;
      port_q     <= port_i;
      addr_q     <= address_i;
      data_q     <= data_i;
      qln_q      <= q_line_i;
    end
  end

  // tick: blanking window and interrupt from the counters before advance
  assign is_tick   = (req_type_q == REQ_TICK);
  assign blank_new = (line_q < cfg_first_q) || (line_q >= cfg_end_q);
  assign irq_new   = is_tick && (line_q == cfg_irq_q) && (cyc_q == CW'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      mode_q    <= '0;
      ptr_q     <= '0;
      blank_q   <= 1'b1;
      line_q    <= '0;
      cyc_q     <= '0;
      irq_q     <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + GAW'(1);
      end
      if (cmd_i.exec_page) begin
        irq_q <= irq_new;
        if (is_tick) begin
          blank_q <= blank_new;
          if (cyc_q == CW'(CYCLES_PER_LINE - 1)) begin
            cyc_q <= '0;
            if (line_q == LINE_W'(LINES_PER_FRAME - 1)) begin
              line_q <= '0;
            end else begin
              line_q <= line_q + LINE_W'(1);
            end
          end else begin
            cyc_q <= cyc_q + CW'(1);
          end
        end else if (req_type_q == REQ_PORT_WR) begin
          case (port_q)
            PORT_MODE: begin
              mode_q <= {addr_q[7], addr_q[6], addr_q[5], addr_q[3], addr_q[0]};
              ptr_q  <= addr_q[0] ? addr_q[PA_W-1:0] : '0;
            end
            PORT_PTR: begin
              ptr_q <= addr_q[PA_W-1:0];
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mask_q  <= RST_PAGE_MASK;
      cfg_first_q <= RST_FIRST_LINE;
      cfg_end_q   <= RST_END_LINE;
      cfg_irq_q   <= RST_IRQ_LINE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PAGE_MASK:  cfg_mask_q  <= cfg_data_i;
        CFG_FIRST_LINE: cfg_first_q <= cfg_data_i[LINE_W-1:0];
        CFG_END_LINE:   cfg_end_q   <= cfg_data_i[LINE_W-1:0];
        CFG_IRQ_LINE:   cfg_irq_q   <= cfg_data_i[LINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // result assembly
  assign char_rd_hit = (req_type_q == REQ_CHAR_RD) && blank_q;
  assign color_new   = char_rd_hit ? color_rd_q : latched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latched_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      latched_q <= color_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if ((req_type_q == REQ_PAGE_RD) && blank_q) begin
        read_data_o <= page_rd_q;
      end else if (char_rd_hit) begin
        read_data_o <= glyph_rd_q;
      end else begin
        read_data_o <= IDLE_BYTE;
      end
      color_bit_o   <= color_new;
      irq_o         <= irq_q;
      in_blanking_o <= blank_q;
    end
  end

endmodule

`default_nettype wire

>>> rtl/video_interface_bus_and_timing.sv
// top level of the video bus interface and scan timing block
// depends on vibt_pkg, vibt_if, vibt_ctrl and vibt_dp
`timescale 1ns / 1ps
`default_nettype none

// channel    dir   handshake          payload
// req_i      in    valid / ready      req_type, port, address, data, q_line
// rsp_o      out   valid / ready      read_data, color_bit, irq, in_blanking
// cfg        in    cfg_we_i only      cfg_idx_i, cfg_data_i
//
// each item goes through a page ram read, then the dependent glyph ram read,
// then the result register load, which overlaps with taking the next item
// after reset a clearing sweep over GLYPH_DEPTH entries zeroes both rams and the
// color bits; req_i.ready stays low until it ends, config writes work meanwhile
// a result waiting in the output register holds the sequencer in its last step
// until rsp_o.ready, and one item at a time is in flight

module video_interface_bus_and_timing import vibt_pkg::*; #(
  parameter int unsigned PAGE_DEPTH      = 2048,
  parameter int unsigned GLYPH_DEPTH     = 4096,
  parameter int unsigned CYCLES_PER_LINE = 14,
  parameter int unsigned LINES_PER_FRAME = 262
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire [CFGIX_W-1:0] cfg_idx_i,
  input  wire [CFG_W-1:0]   cfg_data_i,
  vibt_req_if.sink          req_i,
  vibt_rsp_if.source        rsp_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: clear sweep, idle, page step, glyph step, result step
  vibt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // rams, counters and registers; color control and home address never
  // reach a bus result, so ports 3 and 7 leave no state here
  vibt_dp #(
    .PAGE_DEPTH      (PAGE_DEPTH),
    .GLYPH_DEPTH     (GLYPH_DEPTH),
    .CYCLES_PER_LINE (CYCLES_PER_LINE),
    .LINES_PER_FRAME (LINES_PER_FRAME)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_i.req_type),
    .port_i        (req_i.port),
    .address_i     (req_i.address),
    .data_i        (req_i.data),
    .q_line_i      (req_i.q_line),
    .read_data_o   (rsp_o.read_data),
    .color_bit_o   (rsp_o.color_bit),
    .irq_o         (rsp_o.irq),
    .in_blanking_o (rsp_o.in_blanking)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb_video_interface_bus_and_timing.sv
// self-checking bench for the video bus interface and scan timing block
// a queue-fed driver, a monitor and an item-level predictor of ram, port and tick behavior
// depends on vibt_pkg, vibt_if and the block's rtl
`timescale 1ns / 1ps

module tb_video_interface_bus_and_timing;
  import vibt_pkg::*;

  localparam int unsigned PAGE_DEPTH      = 2048;
  localparam int unsigned GLYPH_DEPTH     = 4096;
  localparam int unsigned CYCLES_PER_LINE = 14;
  localparam int unsigned LINES_PER_FRAME = 262;

  // clearing sweep plus ~1500 items under heavy stalls, with a wide margin
  localparam int unsigned CYCLE_LIMIT = 300_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned BATCH_ITEMS = 240;

  // codes the package leaves unnamed
  localparam logic [REQ_W-1:0]  REQ_IDLE_LO = 3'd6;
  localparam logic [REQ_W-1:0]  REQ_IDLE_HI = 3'd7;
  localparam logic [PORT_W-1:0] PORT_COLOUR = 3'd3;
  localparam logic [PORT_W-1:0] PORT_HOME   = 3'd7;
  localparam logic [PORT_W-1:0] PORT_UNUSED = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              q_line;
  } bus_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              color_bit;
    logic              irq;
    logic              in_blanking;
  } bus_rsp_t;

  // clock, reset and everything driven into the block, known from time zero
  logic               clk;
  logic               rst_n    = 1'b0;
  logic               cfg_we   = 1'b0;
  logic [CFGIX_W-1:0] cfg_idx  = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               req_vld  = 1'b0;
  bus_req_t           req_item = '0;
  logic               rsp_rdy  = 1'b0;

  vibt_req_if req_bus ();
  vibt_rsp_if rsp_bus ();

  assign req_bus.valid    = req_vld;
  assign req_bus.req_type = req_item.req_type;
  assign req_bus.port     = req_item.port;
  assign req_bus.address  = req_item.address;
  assign req_bus.data     = req_item.data;
  assign req_bus.q_line   = req_item.q_line;
  assign rsp_bus.ready    = rsp_rdy;

  video_interface_bus_and_timing #(
    .PAGE_DEPTH      (PAGE_DEPTH),
    .GLYPH_DEPTH     (GLYPH_DEPTH),
    .CYCLES_PER_LINE (CYCLES_PER_LINE),
    .LINES_PER_FRAME (LINES_PER_FRAME)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  // items waiting for the driver, and bus results owed by accepted items
  bus_req_t pending [$];
  bus_rsp_t owed_results [$];

  // traffic shaping, set by the stimulus process
  int unsigned send_idle_pct = 0;
  int unsigned rcv_idle_pct  = 0;
  logic        hold_arm      = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned results_seen   = 0;
  int unsigned cycles         = 0;

  // ---------------------------------------------------------------------------
  // predictor state: memories, scan counters, mode and configuration
  // colour control and home address feed only the display side, so they are
  // not tracked; they never change a bus result
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] page_mem   [PAGE_DEPTH];
  logic [DATA_W-1:0] glyph_mem  [GLYPH_DEPTH];
  logic              glyph_tint [GLYPH_DEPTH];
  logic              blanking;
  int unsigned       scan_line;
  int unsigned       scan_cycle;
  logic [MODE_W-1:0] mode_q;
  logic [ADDR_W-1:0] page_ptr;
  logic              tint_latch;
  logic [PA_W-1:0]   page_mask_q;
  logic [LINE_W-1:0] first_line_q;
  logic [LINE_W-1:0] end_line_q;
  logic [LINE_W-1:0] irq_line_q;

  // with cmem set the page pointer replaces the bus offset, cut to 10 bits
  // unless double paging is on
  function automatic logic [ADDR_W-1:0] page_addr(input logic [ADDR_W-1:0] offset);
    if (!mode_q[MB_CMEM]) return offset;
    return mode_q[MB_DBLPAGE] ? page_ptr : {6'd0, page_ptr[9:0]};
  endfunction

  function automatic int unsigned page_slot(input logic [ADDR_W-1:0] pa);
    return int'(pa) & int'(page_mask_q) & (PAGE_DEPTH - 1);
  endfunction

  // glyph address: column * lines per char + row mod lines
  function automatic int unsigned glyph_slot(input logic [ADDR_W-1:0] offset);
    logic [ADDR_W-1:0] pa;
    int unsigned       lines;
    int unsigned       row;
    int unsigned       column;
    pa = page_addr(offset);
    if (mode_q[MB_LINE16] && !mode_q[MB_DBLPAGE]) lines = 16;
    else if (!mode_q[MB_LINE9]) lines = 9;
    else lines = 8;
    row = mode_q[MB_DBLPAGE] ? 32'(offset[2:0]) : 32'(offset[3:0]);
    // page address bit 10 selects the fixed top column
    column = pa[10] ? 32'hff : 32'(page_mem[page_slot(pa)]);
    return (column * lines + row % lines) & (GLYPH_DEPTH - 1);
  endfunction

  // advance the predictor by one accepted item and return its bus result
  function automatic bus_rsp_t bus_result(input bus_req_t it);
    bus_rsp_t    r;
    int unsigned g;
    r.read_data = IDLE_BYTE;
    r.irq       = 1'b0;
    case (it.req_type)
      REQ_TICK: begin
        // blanking and the interrupt look at the counters before they step
        blanking = (scan_line < 32'(first_line_q)) || (scan_line >= 32'(end_line_q));
        r.irq    = (scan_line == 32'(irq_line_q)) && (scan_cycle == 2);
        scan_cycle++;
        if (scan_cycle >= CYCLES_PER_LINE) begin
          scan_cycle = 0;
          scan_line++;
          if (scan_line >= LINES_PER_FRAME) scan_line = 0;
        end
      end
      REQ_PORT_WR: begin
        case (it.port)
          PORT_MODE: begin
            // mode bits come from address bus bits 0, 3, 5, 6 and 7
            mode_q[MB_CMEM]     = it.address[0];
            mode_q[MB_LINE9]    = it.address[3];
            mode_q[MB_LINE16]   = it.address[5];
            mode_q[MB_DBLPAGE]  = it.address[6];
            mode_q[MB_FRESVERT] = it.address[7];
            page_ptr = mode_q[MB_CMEM] ? it.address : '0;
          end
          PORT_PTR: page_ptr = {5'd0, it.address[10:0]};
          default: ;
        endcase
      end
      REQ_PAGE_RD: if (blanking) r.read_data = page_mem[page_slot(page_addr(it.address))];
      REQ_PAGE_WR: if (blanking) page_mem[page_slot(page_addr(it.address))] = it.data;
      REQ_CHAR_RD: begin
        if (blanking) begin
          g           = glyph_slot(it.address);
          tint_latch  = glyph_tint[g];
          r.read_data = glyph_mem[g];
        end
      end
      REQ_CHAR_WR: begin
        if (blanking) begin
          g             = glyph_slot(it.address);
          glyph_mem[g]  = it.data;
          glyph_tint[g] = it.q_line;
        end
      end
      default: ;
    endcase
    r.color_bit   = tint_latch;
    r.in_blanking = blanking;
    return r;
  endfunction

  function automatic bus_req_t item_of(input logic [REQ_W-1:0] kind,
                                       input logic [PORT_W-1:0] prt,
                                       input logic [ADDR_W-1:0] a,
                                       input logic [DATA_W-1:0] d,
                                       input logic q);
    return '{kind, prt, a, d, q};
  endfunction

  // random item: mostly a small address pool so that reads land on earlier
  // writes and page bytes make usable glyph columns; some full-range noise
  function automatic bus_req_t random_item();
    bus_req_t    it;
    int unsigned pick;
    it.port   = PORT_W'($urandom_range(7));
    it.data   = DATA_W'($urandom_range(255));
    it.q_line = 1'($urandom_range(1));
    if ($urandom_range(3) == 0) it.address = 16'($urandom_range(65535));
    else it.address = 16'($urandom_range(63)) | (($urandom_range(7) == 0) ? 16'h0400 : 16'h0000);
    pick = $urandom_range(99);
    if (pick < 33) it.req_type = REQ_TICK;
    else if (pick < 41) begin
      it.req_type = REQ_PORT_WR;
      if ($urandom_range(1)) it.port = $urandom_range(1) ? PORT_MODE : PORT_PTR;
    end
    else if (pick < 53) it.req_type = REQ_PAGE_RD;
    else if (pick < 66) begin
      it.req_type = REQ_PAGE_WR;
      // small page bytes keep glyph columns clustered
      if ($urandom_range(1)) it.data = DATA_W'($urandom_range(7));
    end
    else if (pick < 82) it.req_type = REQ_CHAR_RD;
    else if (pick < 97) it.req_type = REQ_CHAR_WR;
    else it.req_type = $urandom_range(1) ? REQ_IDLE_LO : REQ_IDLE_HI;
    return it;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: an offered item stays on the bus until accepted; the predictor
  // runs at the accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_vld <= 1'b0;
    end else begin
      if (req_vld && req_bus.ready) owed_results.push_back(bus_result(req_item));
      if (!req_vld || req_bus.ready) begin
        if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_item <= pending.pop_front();
          req_vld  <= 1'b1;
        end else begin
          req_vld <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result against the oldest owed one and shapes
  // ready, including one long hold-off counted here
  // ---------------------------------------------------------------------------
  int unsigned hold_left  = 0;
  logic        hold_taken = 1'b0;

  always @(posedge clk or negedge rst_n) begin
    bus_rsp_t want;
    if (!rst_n) begin
      rsp_rdy <= 1'b0;
    end else begin
      if (rsp_rdy && rsp_bus.valid) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with no item outstanding", results_seen));
        end else begin
          want = owed_results.pop_front();
          if (rsp_bus.read_data !== want.read_data)
            log_mismatch($sformatf("result %0d read_data exp %02h got %02h",
                                   results_seen, want.read_data, rsp_bus.read_data));
          if (rsp_bus.color_bit !== want.color_bit)
            log_mismatch($sformatf("result %0d color_bit exp %0b got %0b",
                                   results_seen, want.color_bit, rsp_bus.color_bit));
          if (rsp_bus.irq !== want.irq)
            log_mismatch($sformatf("result %0d irq exp %0b got %0b",
                                   results_seen, want.irq, rsp_bus.irq));
          if (rsp_bus.in_blanking !== want.in_blanking)
            log_mismatch($sformatf("result %0d in_blanking exp %0b got %0b",
                                   results_seen, want.in_blanking, rsp_bus.in_blanking));
        end
      end
      // long hold-off so the block fills and stalls its request side
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rsp_rdy   <= 1'b0;
      end else if (hold_arm && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        rsp_rdy    <= 1'b0;
      end else begin
        rsp_rdy <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // wait until the driver has nothing left and every result is in
  task automatic wait_idle();
    do @(negedge clk);
    while (pending.size() != 0 || req_vld || owed_results.size() != 0);
  endtask

  // one register write, mirrored into the predictor; only called while idle
  task automatic write_cfg(input logic [CFGIX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CFG_W-1:0];
    case (idx)
      CFG_PAGE_MASK:  page_mask_q  = value[PA_W-1:0];
      CFG_FIRST_LINE: first_line_q = value[LINE_W-1:0];
      CFG_END_LINE:   end_line_q   = value[LINE_W-1:0];
      CFG_IRQ_LINE:   irq_line_q   = value[LINE_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int unsigned mask, input int unsigned first,
                           input int unsigned last_line, input int unsigned irq_at);
    write_cfg(CFG_PAGE_MASK, mask);
    write_cfg(CFG_FIRST_LINE, first);
    write_cfg(CFG_END_LINE, last_line);
    write_cfg(CFG_IRQ_LINE, irq_at);
  endtask

  task automatic run_batch(input int unsigned count);
    @(negedge clk);
    repeat (count) pending.push_back(random_item());
    wait_idle();
  endtask

  initial begin
    // predictor reset state
    foreach (page_mem[i]) page_mem[i] = '0;
    foreach (glyph_mem[i]) begin
      glyph_mem[i]  = '0;
      glyph_tint[i] = 1'b0;
    end
    blanking     = 1'b1;
    scan_line    = 0;
    scan_cycle   = 0;
    mode_q       = '0;
    page_ptr     = '0;
    tint_latch   = 1'b0;
    page_mask_q  = RST_PAGE_MASK;
    first_line_q = RST_FIRST_LINE;
    end_line_q   = RST_END_LINE;
    irq_line_q   = RST_IRQ_LINE;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // slow sender, slower receiver
    send_idle_pct = 30;
    rcv_idle_pct  = 67;

    // directed: default window keeps the bus in blanking at line zero
    @(negedge clk);
    pending.push_back(item_of(REQ_PAGE_WR, '0, 16'h0005, 8'h41, 1'b0));
    pending.push_back(item_of(REQ_PAGE_RD, '0, 16'h0005, 8'h00, 1'b0));
    // top page entry with every field at its maximum
    pending.push_back(item_of(REQ_PAGE_WR, PORT_HOME, 16'hffff, 8'hff, 1'b1));
    pending.push_back(item_of(REQ_PAGE_RD, PORT_HOME, 16'hffff, 8'hff, 1'b1));
    // glyph write stores q as the color bit, read latches it
    pending.push_back(item_of(REQ_CHAR_WR, '0, 16'h0003, 8'ha5, 1'b1));
    pending.push_back(item_of(REQ_CHAR_RD, '0, 16'h0003, 8'h00, 1'b0));
    // page address bit 10 forces the top column, row 15 wraps mod 9
    pending.push_back(item_of(REQ_CHAR_WR, '0, 16'h040f, 8'h5a, 1'b0));
    pending.push_back(item_of(REQ_CHAR_RD, '0, 16'h040f, 8'h00, 1'b1));
    // all mode bits: cmem through the pointer, double paging, 8 lines
    pending.push_back(item_of(REQ_PORT_WR, PORT_MODE, 16'h00e9, 8'h00, 1'b0));
    pending.push_back(item_of(REQ_CHAR_RD, '0, 16'h000f, 8'h00, 1'b0));
    pending.push_back(item_of(REQ_PORT_WR, PORT_PTR, 16'hffff, 8'h00, 1'b0));
    pending.push_back(item_of(REQ_PAGE_RD, '0, 16'h0000, 8'h00, 1'b0));
    // ports with no bus-visible effect, then the unused request codes
    pending.push_back(item_of(REQ_PORT_WR, PORT_COLOUR, 16'h0000, 8'h80, 1'b0));
    pending.push_back(item_of(REQ_PORT_WR, PORT_HOME, 16'hffff, 8'h00, 1'b0));
    pending.push_back(item_of(REQ_PORT_WR, '0, 16'h1234, 8'h55, 1'b1));
    pending.push_back(item_of(REQ_PORT_WR, PORT_UNUSED, 16'hffff, 8'hff, 1'b1));
    pending.push_back(item_of(REQ_IDLE_LO, '0, 16'h0005, 8'h00, 1'b0));
    pending.push_back(item_of(REQ_IDLE_HI, '0, 16'h0005, 8'h00, 1'b1));
    // cmem with 16 lines per char
    pending.push_back(item_of(REQ_PORT_WR, PORT_MODE, 16'h0021, 8'h00, 1'b0));
    pending.push_back(item_of(REQ_CHAR_WR, '0, 16'h000e, 8'h3c, 1'b1));
    wait_idle();

    // display window on line zero only, interrupt on line zero
    configure(RST_PAGE_MASK, 0, 1, 0);
    @(negedge clk);
    // third tick of the line raises the interrupt
    repeat (3) pending.push_back(item_of(REQ_TICK, '0, 16'h0000, 8'h00, 1'b0));
    // active display: reads give the idle byte, writes are dropped
    pending.push_back(item_of(REQ_PAGE_RD, '0, 16'h0005, 8'h00, 1'b0));
    pending.push_back(item_of(REQ_PAGE_WR, '0, 16'h0005, 8'h99, 1'b0));
    pending.push_back(item_of(REQ_CHAR_RD, '0, 16'h0003, 8'h00, 1'b0));
    pending.push_back(item_of(REQ_CHAR_WR, '0, 16'h0003, 8'h77, 1'b0));
    wait_idle();

    // random part; some windows are placed just ahead of the current scan line
    // so that display and interrupt are reached within those batches
    configure(2047, scan_line + 1, scan_line + 4, scan_line + 1);
    hold_arm = 1'b1;
    run_batch(BATCH_ITEMS);
    configure(0, 0, 0, 0);
    run_batch(BATCH_ITEMS);

    // fast receiver, slow sender
    send_idle_pct = 67;
    rcv_idle_pct  = 30;
    configure(11'h2aa, scan_line + 2, scan_line + 3, scan_line + 2);
    run_batch(BATCH_ITEMS);
    configure(11'h555, 511, 0, 511);
    run_batch(BATCH_ITEMS);

    // back to back
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    configure(2047, scan_line + 1, 511, scan_line + 1);
    run_batch(BATCH_ITEMS);
    configure(11'h7f0, scan_line + 1, scan_line + 5, scan_line + 3);
    run_batch(BATCH_ITEMS);

    // drain: catch any stray result after the last one owed
    repeat (20) @(posedge clk);
    if (owed_results.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", owed_results.size()));
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
